// ----- hdl/dcf_pkg.sv -----
package dcf_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int FRACTION_BITS   = 14;
  localparam int CORDIC_STEPS    = 62;
  localparam int NORM_MSB        = 59;
  localparam int ACC_W           = 64;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  typedef struct packed {
    logic neg;
    logic zero;
    logic full;
  } lane_flags_t;

  // shift-subtract division, only evaluated on constants
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q62 by alternating series with truncated terms
  function automatic logic [63:0] atan_recip_q62(input logic [63:0] n);
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] t;
    pw  = udiv64(64'd1 << 62, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (pw != 64'd0) begin
        t = udiv64(pw, 64'(2 * k + 1));
        if ((k % 2) == 0) sum = sum + t;
        else sum = sum - t;
        pw = udiv64(udiv64(pw, n), n);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] angle_q60(input int idx);
    logic [63:0] s;
    if (idx == 0) s = atan_recip_q62(64'd2) + atan_recip_q62(64'd3) + 64'd2;
    else s = atan_recip_q62(64'd1 << idx) + 64'd2;
    return s >> 2;
  endfunction

  localparam logic [63:0] QUARTER_PI_Q60 = angle_q60(0);

  // stages inside the unwarp pipeline
  function automatic int unwarp_latency(input int fb);
    return 2 + CORDIC_STEPS + 1 + (fb + 2) + 1;
  endfunction

endpackage

// ----- hdl/dcf_if.sv -----
interface dcf_dir_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;
  logic signed [CW-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface dcf_uv_if #(
  parameter int FB = 14
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           face;
  logic signed [FB+1:0] u_coord;
  logic signed [FB+1:0] v_coord;

  modport source (output valid, output face, output u_coord, output v_coord, input ready);
  modport sink (input valid, input face, input u_coord, input v_coord, output ready);
endinterface

// ----- hdl/dcf_unwarp.sv -----
module dcf_unwarp #(
  parameter int CW = dcf_pkg::COMPONENT_WIDTH,
  parameter int FB = dcf_pkg::FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ce,
  input  logic                 in_v,
  input  logic [2:0]           in_face,
  input  logic signed [CW:0]   in_p [2],
  input  logic [CW-1:0]        in_m,
  output logic                 out_v,
  output logic [2:0]           last_face,
  output logic signed [FB+1:0] out_c [2]
);
  import dcf_pkg::*;

  localparam int LAT  = unwarp_latency(FB);
  localparam int MSBW = $clog2(CW);
  localparam int QW   = FB + 2;

  logic [LAT-1:0] vld_r;
  logic [2:0]     face_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[LAT-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      face_r[0] <= in_face;
      for (int s = 1; s < LAT; s++) face_r[s] <= face_r[s-1];
    end
  end

  assign out_v     = vld_r[LAT-1];
  assign last_face = face_r[LAT-1];

  // msb position of the dominant magnitude
  logic [MSBW-1:0] msb;
  always_comb begin
    msb = '0;
    for (int b = 0; b < CW; b++) begin
      if (in_m[b]) msb = MSBW'(b);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [CW-1:0]   a0_r;
    logic [CW-1:0]   m0_r;
    logic [MSBW-1:0] msb0_r;
    lane_flags_t     f0_r;
    logic [CW-1:0]   abs_p;

    assign abs_p = in_p[l][CW] ? CW'(-in_p[l]) : CW'(in_p[l]);

    always_ff @(posedge clk) begin
      if (ce) begin
        a0_r      <= abs_p;
        m0_r      <= in_m;
        msb0_r    <= msb;
        f0_r.neg  <= in_p[l][CW];
        f0_r.zero <= (abs_p == '0);
        f0_r.full <= (abs_p >= in_m);
      end
    end

    logic [6:0] sh;
    assign sh = 7'(NORM_MSB) - 7'(msb0_r);

    logic signed [ACC_W-1:0] xw [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0] yw [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0] zw [CORDIC_STEPS+1];
    lane_flags_t             fw [CORDIC_STEPS+1];

    logic signed [ACC_W-1:0] x1_r;
    logic signed [ACC_W-1:0] y1_r;
    lane_flags_t             f1_r;

    always_ff @(posedge clk) begin
      if (ce) begin
        x1_r <= signed'({{(ACC_W-CW){1'b0}}, m0_r} << sh);
        y1_r <= signed'({{(ACC_W-CW){1'b0}}, a0_r} << sh);
        f1_r <= f0_r;
      end
    end

    assign xw[0] = x1_r;
    assign yw[0] = y1_r;
    assign zw[0] = '0;
    assign fw[0] = f1_r;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam logic signed [ACC_W-1:0] ANG = signed'(angle_q60(i));
      logic signed [ACC_W-1:0] x_r;
      logic signed [ACC_W-1:0] y_r;
      logic signed [ACC_W-1:0] z_r;
      lane_flags_t             f_r;

      always_ff @(posedge clk) begin
        if (ce) begin
          if (!yw[i][ACC_W-1]) begin
            x_r <= xw[i] + (yw[i] >>> i);
            y_r <= yw[i] - (xw[i] >>> i);
            z_r <= zw[i] + ANG;
          end else begin
            x_r <= xw[i] - (yw[i] >>> i);
            y_r <= yw[i] + (xw[i] >>> i);
            z_r <= zw[i] - ANG;
          end
          f_r <= fw[i];
        end
      end

      assign xw[i+1] = x_r;
      assign yw[i+1] = y_r;
      assign zw[i+1] = z_r;
      assign fw[i+1] = f_r;
    end

    // clamp angle to [0, pi/4]
    logic [ACC_W-1:0] zc_r;
    lane_flags_t      fc_r;
    logic signed [ACC_W-1:0] zfin;
    assign zfin = zw[CORDIC_STEPS];

    always_ff @(posedge clk) begin
      if (ce) begin
        if (zfin[ACC_W-1]) zc_r <= '0;
        else if (unsigned'(zfin) > QUARTER_PI_Q60) zc_r <= QUARTER_PI_Q60;
        else zc_r <= unsigned'(zfin);
        fc_r <= fw[CORDIC_STEPS];
      end
    end

    // restoring division by pi/4, one quotient bit per stage
    logic [ACC_W-1:0] rw [QW+1];
    logic [QW-1:0]    qw [QW+1];
    lane_flags_t      dfw [QW+1];

    assign rw[0]  = zc_r;
    assign qw[0]  = '0;
    assign dfw[0] = fc_r;

    for (genvar j = 0; j < QW; j++) begin : g_div
      logic [ACC_W-1:0] r_r;
      logic [QW-1:0]    q_r;
      lane_flags_t      f_r;
      logic             bit_q;
      assign bit_q = (rw[j] >= QUARTER_PI_Q60);

      always_ff @(posedge clk) begin
        if (ce) begin
          r_r <= (bit_q ? rw[j] - QUARTER_PI_Q60 : rw[j]) << 1;
          q_r <= {qw[j][QW-2:0], bit_q};
          f_r <= dfw[j];
        end
      end

      assign rw[j+1]  = r_r;
      assign qw[j+1]  = q_r;
      assign dfw[j+1] = f_r;
    end

    logic [QW-1:0] rnd;
    logic [QW-1:0] mag;
    lane_flags_t   ff;
    assign ff  = dfw[QW];
    assign rnd = (qw[QW] + QW'(1)) >> 1;

    always_comb begin
      priority if (ff.zero) mag = '0;
      else if (ff.full) mag = QW'(1) << FB;
      else mag = rnd;
    end

    logic signed [QW-1:0] c_r;
    always_ff @(posedge clk) begin
      if (ce) begin
        c_r <= ff.neg ? signed'(-mag) : signed'(mag);
      end
    end

    assign out_c[l] = c_r;
  end

endmodule

// ----- hdl/direction_to_cube_face_uv.sv -----
// throughput: one direction per cycle unless the output stalls; a 62-step cordic and a
// one-bit-per-stage divider are fully unrolled into register stages, one step each
// a stalled output lets the pipeline fill up to its last stage before it holds
// reset (synchronous, active low) clears all valid bits; data registers keep junk
module direction_to_cube_face_uv #(
  parameter int COMPONENT_WIDTH = dcf_pkg::COMPONENT_WIDTH,
  parameter int FRACTION_BITS   = dcf_pkg::FRACTION_BITS
) (
  input logic clk,
  input logic rst_n,
  dcf_dir_if.sink  in_dir,
  dcf_uv_if.source out_uv
);
  import dcf_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int FB = FRACTION_BITS;

  logic ce;
  logic pipe_v;
  logic out_valid_r;

  assign ce           = !pipe_v || !out_valid_r || out_uv.ready;
  assign in_dir.ready = ce;

  // input register
  logic                 v0_r;
  logic signed [CW-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_dir.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx_r <= in_dir.dir_x;
      dy_r <= in_dir.dir_y;
      dz_r <= in_dir.dir_z;
    end
  end

  // face select
  logic [CW-1:0]      ax, ay, az;
  logic signed [CW:0] sx, sy, sz;
  logic [2:0]         face_nxt;
  logic [CW-1:0]      m_nxt;
  logic signed [CW:0] nu_nxt, nv_nxt;

  assign ax = dx_r[CW-1] ? CW'(-dx_r) : CW'(dx_r);
  assign ay = dy_r[CW-1] ? CW'(-dy_r) : CW'(dy_r);
  assign az = dz_r[CW-1] ? CW'(-dz_r) : CW'(dz_r);
  assign sx = (CW+1)'(dx_r);
  assign sy = (CW+1)'(dy_r);
  assign sz = (CW+1)'(dz_r);

  always_comb begin
    face_nxt = dx_r[CW-1] ? FACE_NEG_X : FACE_POS_X;
    m_nxt    = ax;
    if (ay > m_nxt) begin
      face_nxt = dy_r[CW-1] ? FACE_NEG_Y : FACE_POS_Y;
      m_nxt    = ay;
    end
    if (az > m_nxt) begin
      face_nxt = dz_r[CW-1] ? FACE_NEG_Z : FACE_POS_Z;
      m_nxt    = az;
    end
  end

  always_comb begin
    unique case (face_nxt)
      FACE_POS_X: begin nu_nxt = sz;  nv_nxt = sy;  end
      FACE_NEG_X: begin nu_nxt = -sz; nv_nxt = sy;  end
      FACE_POS_Y: begin nu_nxt = sx;  nv_nxt = sz;  end
      FACE_NEG_Y: begin nu_nxt = sx;  nv_nxt = -sz; end
      FACE_POS_Z: begin nu_nxt = -sx; nv_nxt = sy;  end
      default:    begin nu_nxt = sx;  nv_nxt = sy;  end
    endcase
  end

  logic               v1_r;
  logic [2:0]         face1_r;
  logic [CW-1:0]      m1_r;
  logic signed [CW:0] p1_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      face1_r <= face_nxt;
      m1_r    <= m_nxt;
      p1_r[0] <= nu_nxt;
      p1_r[1] <= nv_nxt;
    end
  end

  logic [2:0]           pipe_face;
  logic signed [FB+1:0] pipe_c [2];

  dcf_unwarp #(
    .CW(CW),
    .FB(FB)
  ) u_unwarp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_v      (v1_r),
    .in_face   (face1_r),
    .in_p      (p1_r),
    .in_m      (m1_r),
    .out_v     (pipe_v),
    .last_face (pipe_face),
    .out_c     (pipe_c)
  );

  // output register
  logic [2:0]           face_r;
  logic signed [FB+1:0] u_r, v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_uv.ready) begin
      out_valid_r <= pipe_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_uv.ready) begin
      face_r <= pipe_face;
      u_r    <= pipe_c[0];
      v_r    <= pipe_c[1];
    end
  end

  assign out_uv.valid   = out_valid_r;
  assign out_uv.face    = face_r;
  assign out_uv.u_coord = u_r;
  assign out_uv.v_coord = v_r;

`ifndef ASSERT_OFF
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (face_r <= FACE_NEG_Z))
    else $error("face code out of range");

  a_u_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (u_r <= signed'((FB+2)'(1) << FB) && u_r >= -signed'((FB+2)'(1) << FB)))
    else $error("u coordinate beyond unit range");

  a_v_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (v_r <= signed'((FB+2)'(1) << FB) && v_r >= -signed'((FB+2)'(1) << FB)))
    else $error("v coordinate beyond unit range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_v && out_valid_r && !out_uv.ready) |=> (pipe_v && $stable(pipe_face)))
    else $error("pipeline moved while its last stage was blocked");
`endif

endmodule

// ----- bench/direction_to_cube_face_uv_tb.sv -----
module direction_to_cube_face_uv_tb;
  import dcf_pkg::*;

  localparam int CW = dcf_pkg::COMPONENT_WIDTH;
  localparam int FB = dcf_pkg::FRACTION_BITS;
  localparam int STEPS = 62;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } direction_t;

  typedef struct {
    logic [2:0]           face;
    logic signed [FB+1:0] u;
    logic signed [FB+1:0] v;
  } face_uv_t;

  logic clk;
  logic rst_n;

  dcf_dir_if #(.CW(CW)) dir_ch ();
  dcf_uv_if #(.FB(FB)) uv_ch ();

  direction_to_cube_face_uv uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_dir(dir_ch.sink),
    .out_uv(uv_ch.source)
  );

  direction_t pending_dirs[$];
  face_uv_t   expected_uv[$];
  longint     atan_step_q60[STEPS];
  int         mismatches;
  int         dirs_sent;
  int         results_seen;
  int         total_dirs;
  bit         dir_taken;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // atan(1/n) in q62 from the alternating series, terms truncated
  function automatic longint unsigned atan_inv_q62(input longint unsigned n);
    longint unsigned pw;
    longint unsigned acc;
    longint unsigned k;
    pw  = (64'd1 << 62) / n;
    acc = 0;
    k   = 0;
    while (pw != 0) begin
      if (k[0] == 1'b0) acc = acc + pw / (2 * k + 1);
      else acc = acc - pw / (2 * k + 1);
      pw = pw / n / n;
      k++;
    end
    return acc;
  endfunction

  // atan(p/m) * 4/pi in fixed point, m > 0 and |p| <= m
  function automatic longint atan_ratio(input longint p, input longint m);
    longint a, x, y, z, nx, ny, r;
    longint unsigned q, rem, den;
    a = (p < 0) ? -p : p;
    if (a == 0) return 0;
    if (a >= m) return (p < 0) ? -(64'sd1 <<< FB) : (64'sd1 <<< FB);
    x = m;
    y = a;
    while (x < (64'sd1 <<< 59)) begin
      x = x * 2;
      y = y * 2;
    end
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_step_q60[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_step_q60[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > atan_step_q60[0]) z = atan_step_q60[0];
    den = atan_step_q60[0];
    rem = z;
    q   = 0;
    for (int i = 0; i < FB + 2; i++) begin
      q = q << 1;
      if (rem >= den) begin
        q   = q | 1;
        rem = rem - den;
      end
      rem = rem << 1;
    end
    r = (q + 1) >> 1;
    return (p < 0) ? -r : r;
  endfunction

  function automatic face_uv_t project_direction(input direction_t d);
    longint dx, dy, dz, ax, ay, az, m, comp, nu, nv;
    int axis;
    face_uv_t res;
    dx = d.x;
    dy = d.y;
    dz = d.z;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    az = (dz < 0) ? -dz : dz;
    m = ax;
    comp = dx;
    axis = 0;
    if (ay > m) begin
      axis = 1;
      m = ay;
      comp = dy;
    end
    if (az > m) begin
      axis = 2;
      m = az;
      comp = dz;
    end
    res.face = 3'(axis * 2 + ((comp < 0) ? 1 : 0));
    case (res.face)
      FACE_POS_X: begin nu = dz;  nv = dy;  end
      FACE_NEG_X: begin nu = -dz; nv = dy;  end
      FACE_POS_Y: begin nu = dx;  nv = dz;  end
      FACE_NEG_Y: begin nu = dx;  nv = -dz; end
      FACE_POS_Z: begin nu = -dx; nv = dy;  end
      default:    begin nu = dx;  nv = dy;  end
    endcase
    res.u = '0;
    res.v = '0;
    if (m > 0) begin
      res.u = (FB + 2)'(atan_ratio(nu, m));
      res.v = (FB + 2)'(atan_ratio(nv, m));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic add_direction(input int x, input int y, input int z);
    direction_t d;
    d.x = CW'(x);
    d.y = CW'(y);
    d.z = CW'(z);
    pending_dirs.push_back(d);
  endtask

  function automatic int rand_comp(input int lim);
    return $urandom_range(2 * lim, 0) - lim;
  endfunction

  function automatic int rand_sign(input int mag);
    return ($urandom_range(1, 0) == 1) ? -mag : mag;
  endfunction

  // idle percentages per third of the run: sender, then receiver
  function automatic int sender_idle_pct();
    if (dirs_sent < total_dirs / 3) return 10;
    if (dirs_sent < 2 * total_dirs / 3) return 77;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (dirs_sent < total_dirs / 3) return 77;
    if (dirs_sent < 2 * total_dirs / 3) return 10;
    return 0;
  endfunction

  // transfer accounting and result checks at the rising edge
  always @(posedge clk) begin
    face_uv_t want;
    if (rst_n) begin
      if (dir_ch.valid && dir_ch.ready) begin
        direction_t d;
        d.x = dir_ch.dir_x;
        d.y = dir_ch.dir_y;
        d.z = dir_ch.dir_z;
        expected_uv.push_back(project_direction(d));
        dirs_sent++;
        dir_taken = 1'b1;
      end
      if (uv_ch.valid && uv_ch.ready) begin
        if (expected_uv.size() == 0) begin
          report_mismatch("unexpected result, face", uv_ch.face, -1);
        end else begin
          want = expected_uv.pop_front();
          if (uv_ch.face !== want.face) report_mismatch("face", uv_ch.face, want.face);
          if (uv_ch.u_coord !== want.u) report_mismatch("u_coord", uv_ch.u_coord, want.u);
          if (uv_ch.v_coord !== want.v) report_mismatch("v_coord", uv_ch.v_coord, want.v);
        end
        results_seen++;
      end
    end
  end

  // driver and receiver stalls change at the falling edge
  always @(negedge clk) begin
    direction_t d;
    if (!rst_n) begin
      dir_ch.valid <= 1'b0;
      uv_ch.ready  <= 1'b0;
    end else begin
      uv_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct());
      if (!dir_ch.valid || dir_taken) begin
        dir_taken = 1'b0;
        if (pending_dirs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
          d = pending_dirs.pop_front();
          dir_ch.dir_x <= d.x;
          dir_ch.dir_y <= d.y;
          dir_ch.dir_z <= d.z;
          dir_ch.valid <= 1'b1;
        end else begin
          dir_ch.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int kind, mag;
    dir_ch.valid = 1'b0;
    dir_ch.dir_x = '0;
    dir_ch.dir_y = '0;
    dir_ch.dir_z = '0;
    uv_ch.ready  = 1'b0;
    mismatches   = 0;
    dirs_sent    = 0;
    results_seen = 0;
    dir_taken    = 1'b0;
    atan_step_q60[0] = longint'((atan_inv_q62(2) + atan_inv_q62(3) + 2) >> 2);
    for (int i = 1; i < STEPS; i++)
      atan_step_q60[i] = longint'((atan_inv_q62(64'd1 << i) + 2) >> 2);

    // zero vector, each face, ties, full-scale ratios, most negative values
    add_direction(0, 0, 0);
    add_direction(100, 20, -30);
    add_direction(-100, 20, -30);
    add_direction(7, 100, 9);
    add_direction(7, -100, 9);
    add_direction(-5, 3, 100);
    add_direction(-5, 3, -100);
    add_direction(50, 50, 50);
    add_direction(-50, 50, -50);
    add_direction(3, -60, 60);
    add_direction(0, -1, 0);
    add_direction(0, 0, -1);
    add_direction(-32768, -32768, -32768);
    add_direction(-32768, 32767, 0);
    add_direction(32767, -32768, 1);
    add_direction(1, 0, -32768);
    add_direction(32767, 32767, -32767);
    add_direction(32767, 1, -1);
    add_direction(1, 0, 0);
    add_direction(-32768, 0, 0);
    add_direction(3, 2, 1);
    add_direction(-12345, 23456, -30000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(99, 0);
      if (kind < 60) begin
        add_direction(rand_comp(32768) % 32768 - ($urandom_range(63, 0) == 0 ? 1 : 0),
                      $urandom_range(65535, 0) - 32768, $urandom_range(65535, 0) - 32768);
      end else if (kind < 78) begin
        add_direction(rand_comp(8), rand_comp(8), rand_comp(8));
      end else if (kind < 93) begin
        mag = $urandom_range(32767, 1);
        case ($urandom_range(2, 0))
          0: add_direction(rand_sign(mag), rand_sign(mag), rand_comp(mag));
          1: add_direction(rand_comp(mag), rand_sign(mag), rand_sign(mag));
          default: add_direction(rand_sign(mag), rand_comp(mag), rand_sign(mag));
        endcase
      end else begin
        add_direction(($urandom_range(1, 0) == 1) ? -32768 : $urandom_range(65535, 0) - 32768,
                      ($urandom_range(1, 0) == 1) ? -32768 : $urandom_range(65535, 0) - 32768,
                      $urandom_range(65535, 0) - 32768);
      end
    end
    total_dirs = pending_dirs.size();

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_dirs.size() == 0 && !dir_ch.valid && expected_uv.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d directions (directed extremes, ties, all faces, random)", dirs_sent);
    $display("checked %0d face/u/v results under three stall mixes", results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_uv.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/dcf_pkg.sv
hdl/dcf_if.sv
hdl/dcf_unwarp.sv
hdl/direction_to_cube_face_uv.sv
bench/direction_to_cube_face_uv_tb.sv
